@@ rtl/bezier_point_evaluator_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Bezier point evaluator
// ---------------------------------------------------------------------------
`ifndef BEZIER_POINT_EVALUATOR_ASSERT_SVH
`define BEZIER_POINT_EVALUATOR_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BPE_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define BPE_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/bpe_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpe_pkg
// Shared widths, constants and payload types of the Bezier point evaluator.
// ---------------------------------------------------------------------------
package bpe_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int T_FRAC_BITS = 16;
   localparam int T_WIDTH     = T_FRAC_BITS + 1;
   localparam int DEG_WIDTH   = 2;

   // 1.0 in the parameter format
   localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << T_FRAC_BITS;

   // registers in one blend unit, and blend levels for a cubic
   localparam int BLEND_STAGES = 3;
   localparam int NUM_LEVELS   = 3;
   localparam int PIPE_DEPTH   = BLEND_STAGES * NUM_LEVELS;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [T_WIDTH-1:0]            tpar_type;
   typedef logic [DEG_WIDTH-1:0]          degree_type;

   typedef struct packed {
      degree_type degree;
      coord_type  p0_x;
      coord_type  p0_y;
      coord_type  p1_x;
      coord_type  p1_y;
      coord_type  p2_x;
      coord_type  p2_y;
      coord_type  p3_x;
      coord_type  p3_y;
      tpar_type   param_t;
   } req_payload_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
   } rsp_payload_type;

endpackage

@@ rtl/bpe_blend.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpe_blend
// Three-stage blend a*(1-t) + b*t, rounded half up, with a pass-through.
// ---------------------------------------------------------------------------
module bpe_blend
   import bpe_pkg::*;
(
   input  logic      clock,
   input  logic      en,
   input  coord_type a,
   input  coord_type b,
   input  tpar_type  t,
   input  logic      bypass,
   output coord_type r
);

   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + T_WIDTH + 1;
   localparam logic signed [PROD_WIDTH-1:0] HALF = PROD_WIDTH'(1) << (T_FRAC_BITS - 1);

   // stage 1: difference
   logic signed [DIFF_WIDTH-1:0] diff_ff, diff_in;
   coord_type                    a1_ff;
   tpar_type                     t1_ff;
   logic                         byp1_ff;

   // stage 2: product
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   coord_type                    a2_ff;
   logic                         byp2_ff;

   // stage 3: rounded result
   logic signed [PROD_WIDTH-1:0] rnd;
   logic signed [T_WIDTH:0]      t_ext;
   coord_type                    r_ff, r_in;

   // a*(1-t) + b*t == a + (b-a)*t, so one multiply per blend
   assign diff_in = DIFF_WIDTH'(b) - DIFF_WIDTH'(a);
   assign t_ext   = $signed({1'b0, t1_ff});
   assign prod_in = PROD_WIDTH'(diff_ff) * PROD_WIDTH'(t_ext);

   always_comb begin
      rnd  = (prod_ff + HALF) >>> T_FRAC_BITS;
      r_in = byp2_ff ? a2_ff : coord_type'(a2_ff + rnd[COORD_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         a1_ff   <= a;
         t1_ff   <= t;
         byp1_ff <= bypass;
         prod_ff <= prod_in;
         a2_ff   <= a1_ff;
         byp2_ff <= byp1_ff;
         r_ff    <= r_in;
      end
   end

   assign r = r_ff;

endmodule

@@ rtl/bezier_point_evaluator.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bezier_point_evaluator
// Pipelined de Casteljau evaluation of a point on a 2D Bezier of degree 0..3.
// ---------------------------------------------------------------------------
//   channel | ports               | payload
//   --------+---------------------+-------------------------------
//   request | req_valid/req_stall | degree, p0..p3 x/y, param_t
//   result  | rsp_valid/rsp_stall | point_x, point_y
//
// One item per cycle while the result is not stalled; three blend levels of three
// register stages each (difference, multiply, round and add).
// Synchronous reset clears only the valid bits.
// A stalled result freezes the whole pipeline; bubbles are not squeezed.
// ---------------------------------------------------------------------------
`include "bezier_point_evaluator_assert.svh"

module bezier_point_evaluator
   import bpe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int CARRY_DEPTH = BLEND_STAGES * (NUM_LEVELS - 1);

   logic                 en;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   degree_type           deg_ff [CARRY_DEPTH];
   tpar_type             t_ff   [CARRY_DEPTH];
   tpar_type             t_sat;

   coord_type in_x [4];
   coord_type in_y [4];
   coord_type l1_x [3];
   coord_type l1_y [3];
   coord_type l2_x [2];
   coord_type l2_y [2];
   coord_type l3_x;
   coord_type l3_y;

   logic byp1, byp2, byp3;

   // whole pipeline moves unless the output holds a stalled transfer
   assign en        = ~(valid_ff[PIPE_DEPTH-1] & rsp_stall);
   assign req_stall = ~en;
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // t above one saturates to one
   assign t_sat = (req_payload.param_t > T_ONE) ? T_ONE : req_payload.param_t;

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff[0] <= req_payload.degree;
         t_ff[0]   <= t_sat;
         for (int i = 1; i < CARRY_DEPTH; i++) begin
            deg_ff[i] <= deg_ff[i-1];
            t_ff[i]   <= t_ff[i-1];
         end
      end
   end

   assign in_x[0] = req_payload.p0_x;
   assign in_x[1] = req_payload.p1_x;
   assign in_x[2] = req_payload.p2_x;
   assign in_x[3] = req_payload.p3_x;
   assign in_y[0] = req_payload.p0_y;
   assign in_y[1] = req_payload.p1_y;
   assign in_y[2] = req_payload.p2_y;
   assign in_y[3] = req_payload.p3_y;

   // levels past the degree pass the points through unchanged
   assign byp1 = (req_payload.degree < 2'd1);
   assign byp2 = (deg_ff[BLEND_STAGES-1] < 2'd2);
   assign byp3 = (deg_ff[CARRY_DEPTH-1] < 2'd3);

   for (genvar i = 0; i < 3; i++) begin : g_level1
      bpe_blend u_bx (
         .clock(clock), .en(en), .a(in_x[i]), .b(in_x[i+1]),
         .t(t_sat), .bypass(byp1), .r(l1_x[i])
      );
      bpe_blend u_by (
         .clock(clock), .en(en), .a(in_y[i]), .b(in_y[i+1]),
         .t(t_sat), .bypass(byp1), .r(l1_y[i])
      );
   end

   for (genvar i = 0; i < 2; i++) begin : g_level2
      bpe_blend u_bx (
         .clock(clock), .en(en), .a(l1_x[i]), .b(l1_x[i+1]),
         .t(t_ff[BLEND_STAGES-1]), .bypass(byp2), .r(l2_x[i])
      );
      bpe_blend u_by (
         .clock(clock), .en(en), .a(l1_y[i]), .b(l1_y[i+1]),
         .t(t_ff[BLEND_STAGES-1]), .bypass(byp2), .r(l2_y[i])
      );
   end

   bpe_blend u_l3_x (
      .clock(clock), .en(en), .a(l2_x[0]), .b(l2_x[1]),
      .t(t_ff[CARRY_DEPTH-1]), .bypass(byp3), .r(l3_x)
   );
   bpe_blend u_l3_y (
      .clock(clock), .en(en), .a(l2_y[0]), .b(l2_y[1]),
      .t(t_ff[CARRY_DEPTH-1]), .bypass(byp3), .r(l3_y)
   );

   assign rsp_payload.point_x = l3_x;
   assign rsp_payload.point_y = l3_y;

   `BPE_ASSERT_NEXT(a_req_enters, req_valid && !req_stall, valid_ff[0], "transfer not in pipe")
   `BPE_ASSERT_NEXT(a_pipe_frozen, req_stall, $stable(valid_ff), "pipeline moved while stalled")
   `BPE_ASSERT_NEXT(a_last_stage, valid_ff[PIPE_DEPTH-2] && en, rsp_valid, "item lost at output")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for bezier_point_evaluator. Splines of degree 0..3 are
// sent with random gaps and result stalls; each result is compared with a
// de Casteljau evaluation done here in 64-bit fixed point.
// ---------------------------------------------------------------------------
module tb;
   import bpe_pkg::*;

   localparam longint ONE_T     = longint'(T_ONE);
   localparam longint HALF_LSB  = longint'(1) <<< (T_FRAC_BITS - 1);
   localparam int     NUM_RANDOM = 1100;
   localparam int     DRAIN_LIMIT = 4000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   rsp_payload_type expected_points[$];
   int              error_count;
   bit              req_gaps_on;
   bit              rsp_gaps_on;

   bezier_point_evaluator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("[bezier_point_evaluator] ERROR");
      $finish;
   end

   // a*(1-t) + b*t, rounded half up
   function automatic longint lerp_fixed(longint a, longint b, longint t);
      longint acc;
      acc = a * (ONE_T - t) + b * t + HALF_LSB;
      return acc >>> T_FRAC_BITS;
   endfunction

   function automatic rsp_payload_type eval_bezier_point(req_payload_type item);
      longint          px[4];
      longint          py[4];
      longint          t;
      int              deg;
      rsp_payload_type pt;
      t = longint'(item.param_t);
      if (t > ONE_T)
         t = ONE_T;
      deg = int'(item.degree);
      px[0] = $signed(item.p0_x);  py[0] = $signed(item.p0_y);
      px[1] = $signed(item.p1_x);  py[1] = $signed(item.p1_y);
      px[2] = $signed(item.p2_x);  py[2] = $signed(item.p2_y);
      px[3] = $signed(item.p3_x);  py[3] = $signed(item.p3_y);
      for (int j = 1; j <= deg; j++) begin
         for (int i = 0; i + j <= deg; i++) begin
            px[i] = lerp_fixed(px[i], px[i+1], t);
            py[i] = lerp_fixed(py[i], py[i+1], t);
         end
      end
      pt.point_x = coord_type'(px[0]);
      pt.point_y = coord_type'(py[0]);
      return pt;
   endfunction

   function automatic coord_type random_coord();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            case ($urandom_range(0, 3))
               0: return coord_type'(32'h7fff_ffff);
               1: return coord_type'(32'h8000_0000);
               2: return coord_type'(0);
               default: return coord_type'(-1);
            endcase
         end
         1, 2, 3, 4: return coord_type'($signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic tpar_type random_param();
      case ($urandom_range(0, 9))
         0: return tpar_type'(0);
         1: return T_ONE;
         2: return tpar_type'($urandom_range(int'(T_ONE) + 1, (1 << T_WIDTH) - 1));
         default: return tpar_type'($urandom_range(0, int'(T_ONE) - 1));
      endcase
   endfunction

   function automatic req_payload_type make_spline(int deg, tpar_type t);
      req_payload_type item;
      item.degree  = degree_type'(deg);
      item.p0_x    = random_coord();  item.p0_y = random_coord();
      item.p1_x    = random_coord();  item.p1_y = random_coord();
      item.p2_x    = random_coord();  item.p2_y = random_coord();
      item.p3_x    = random_coord();  item.p3_y = random_coord();
      item.param_t = t;
      return item;
   endfunction

   // Called right after a rising edge; returns at the edge of the transfer.
   task automatic send_item(input req_payload_type item);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_points.push_back(eval_bezier_point(item));
   endtask

   // result side back-pressure
   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         n = rsp_gaps_on ? $urandom_range(0, 5) : 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do
            @(posedge clock);
         while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type exp_pt;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("result transfer with no expected point: x %0d, y %0d",
                   rsp_payload.point_x, rsp_payload.point_y);
            error_count++;
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_payload.point_x !== exp_pt.point_x) begin
               $error("point_x mismatch: expected %0d, actual %0d",
                      exp_pt.point_x, rsp_payload.point_x);
               error_count++;
            end
            if (rsp_payload.point_y !== exp_pt.point_y) begin
               $error("point_y mismatch: expected %0d, actual %0d",
                      exp_pt.point_y, rsp_payload.point_y);
               error_count++;
            end
         end
      end
   end

   task automatic test_degree_zero();
      send_item(make_spline(0, random_param()));
      send_item(make_spline(0, tpar_type'((1 << T_WIDTH) - 1)));
   endtask

   task automatic test_parameter_ends();
      for (int d = 1; d <= 3; d++) begin
         send_item(make_spline(d, tpar_type'(0)));
         send_item(make_spline(d, T_ONE));
      end
   endtask

   task automatic test_t_above_one();
      send_item(make_spline(3, T_ONE + tpar_type'(1)));
      send_item(make_spline(3, tpar_type'((1 << T_WIDTH) - 1)));
      send_item(make_spline(2, tpar_type'($urandom_range(int'(T_ONE) + 1,
                                                         (1 << T_WIDTH) - 1))));
   endtask

   task automatic test_coordinate_extremes();
      req_payload_type item;
      tpar_type        tvals[3];
      tvals[0] = T_ONE >> 1;
      tvals[1] = tpar_type'(1);
      tvals[2] = T_ONE - tpar_type'(1);
      foreach (tvals[k]) begin
         item.degree = degree_type'(3);
         item.p0_x = coord_type'(32'h7fff_ffff);  item.p0_y = coord_type'(32'h8000_0000);
         item.p1_x = coord_type'(32'h8000_0000);  item.p1_y = coord_type'(32'h7fff_ffff);
         item.p2_x = coord_type'(32'h7fff_ffff);  item.p2_y = coord_type'(32'h8000_0000);
         item.p3_x = coord_type'(32'h8000_0000);  item.p3_y = coord_type'(32'h7fff_ffff);
         item.param_t = tvals[k];
         send_item(item);
      end
      item = '{degree: 3, p0_x: 32'h8000_0000, p0_y: 32'h8000_0000,
               p1_x: 32'h8000_0000, p1_y: 32'h8000_0000, p2_x: 32'h8000_0000,
               p2_y: 32'h8000_0000, p3_x: 32'h8000_0000, p3_y: 32'h8000_0000,
               param_t: 17'h0_5555};
      send_item(item);
      item = '{degree: 3, p0_x: 32'h7fff_ffff, p0_y: 32'h7fff_ffff,
               p1_x: 32'h7fff_ffff, p1_y: 32'h7fff_ffff, p2_x: 32'h7fff_ffff,
               p2_y: 32'h7fff_ffff, p3_x: 32'h7fff_ffff, p3_y: 32'h7fff_ffff,
               param_t: 17'h0_aaaa};
      send_item(item);
   endtask

   // points above the degree carry extremes; they must not leak in
   task automatic test_unused_points();
      req_payload_type item;
      item = make_spline(1, random_param());
      item.p2_x = coord_type'(32'h7fff_ffff);  item.p2_y = coord_type'(32'h8000_0000);
      item.p3_x = coord_type'(32'h8000_0000);  item.p3_y = coord_type'(32'h7fff_ffff);
      send_item(item);
      item = make_spline(2, random_param());
      item.p3_x = coord_type'(32'h7fff_ffff);  item.p3_y = coord_type'(32'h8000_0000);
      send_item(item);
   endtask

   // exact halves: +0.5 LSB rounds up to 1, -0.5 LSB rounds up to 0
   task automatic test_round_half_up();
      req_payload_type item;
      item = '0;
      item.degree  = degree_type'(1);
      item.param_t = T_ONE >> 1;
      item.p1_x    = coord_type'(1);
      item.p1_y    = coord_type'(-1);
      send_item(item);
      item.p0_x = coord_type'(-1);
      item.p1_x = coord_type'(-2);
      item.p0_y = coord_type'(3);
      item.p1_y = coord_type'(4);
      send_item(item);
   endtask

   task automatic test_random_splines();
      req_payload_type item;
      coord_type       base_x;
      coord_type       base_y;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 64 == 0) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_gaps_on = ($urandom_range(0, 3) != 0);
         end
         item = make_spline($urandom_range(0, 3), random_param());
         // some curves with close control points, as a real outline has
         if ($urandom_range(0, 3) == 0) begin
            base_x = coord_type'($urandom);
            base_y = coord_type'($urandom);
            base_x = base_x >>> 1;
            base_y = base_y >>> 1;
            item.p0_x = base_x + coord_type'($urandom_range(0, 32'h000f_ffff));
            item.p0_y = base_y + coord_type'($urandom_range(0, 32'h000f_ffff));
            item.p1_x = base_x + coord_type'($urandom_range(0, 32'h000f_ffff));
            item.p1_y = base_y + coord_type'($urandom_range(0, 32'h000f_ffff));
            item.p2_x = base_x + coord_type'($urandom_range(0, 32'h000f_ffff));
            item.p2_y = base_y + coord_type'($urandom_range(0, 32'h000f_ffff));
            item.p3_x = base_x + coord_type'($urandom_range(0, 32'h000f_ffff));
            item.p3_y = base_y + coord_type'($urandom_range(0, 32'h000f_ffff));
         end
         send_item(item);
      end
   endtask

   initial begin
      int waited;
      error_count  = 0;
      req_gaps_on  = 1'b1;
      rsp_gaps_on  = 1'b1;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_degree_zero();
      test_parameter_ends();
      test_t_above_one();
      test_coordinate_extremes();
      test_unused_points();
      test_round_half_up();
      test_random_splines();
      req_valid <= 1'b0;

      waited = 0;
      while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_points.size() != 0) begin
         $error("%0d expected points never arrived", expected_points.size());
         error_count++;
      end
      // catch any stray result after the last one
      repeat (2 * PIPE_DEPTH + 8) @(posedge clock);

      if (error_count == 0)
         $display("[bezier_point_evaluator] OK");
      else
         $display("[bezier_point_evaluator] ERROR");
      $finish;
   end

endmodule
